// ===== rtl/point_affine_transform_close_crop_top_macros.svh =====
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef POINT_AFFINE_TRANSFORM_CLOSE_CROP_TOP_MACROS_SVH
`define POINT_AFFINE_TRANSFORM_CLOSE_CROP_TOP_MACROS_SVH

// same-cycle implication
`define PACT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PACT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pact_pkg.sv =====
package pact_pkg;

  localparam int CW        = 20;
  localparam int FRAC      = 14;
  localparam int COEF_W    = 16;
  localparam int PW        = COEF_W + CW;
  localparam int AW        = PW + 2;
  localparam int RW        = AW - FRAC;
  localparam int SQW       = 2 * CW + 1;
  localparam int RAD_W     = 40;
  localparam int LAT_W     = 19;
  localparam int CMPW      = (SQW > RAD_W) ? SQW : RAD_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [1:0] CLS_FINITE   = 2'd0;
  localparam logic [1:0] CLS_INFINITE = 2'd1;

  localparam logic [CFG_W-1:0] ROW_X_RST  = 64'h4000_0000_0000_0000;
  localparam logic [CFG_W-1:0] ROW_Y_RST  = 64'h0000_4000_0000_0000;
  localparam logic [CFG_W-1:0] ROW_Z_RST  = 64'h0000_0000_4000_0000;
  localparam logic [RAD_W-1:0] RADIUS_RST = 40'd7290000;
  localparam logic [LAT_W-1:0] LAT_RST    = 19'd1250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_Z,
    REG_XFORM_EN,
    REG_RADIUS_SQ,
    REG_LATERAL
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] pt_x;
    logic signed [CW-1:0] pt_y;
    logic signed [CW-1:0] pt_z;
    logic [7:0]           pt_intensity;
    logic [6:0]           pt_ring;
    logic                 from_secondary;
    logic [1:0]           coord_class;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic [7:0]           out_intensity;
    logic [6:0]           out_ring;
    logic                 out_infinite;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [7:0]           intensity;
    logic [6:0]           ring;
    logic                 xform;
    logic                 infinite;
  } mid_item_t;

  typedef struct packed {
    logic [2:0][CFG_W-1:0] rows;
    logic [RAD_W-1:0]      radius_sq;
    logic [LAT_W-1:0]      lateral;
  } cfg_t;

endpackage

// ===== rtl/pact_front.sv =====
module pact_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  pact_pkg::in_item_t   in_data,
  input  logic                 xform_en,
  input  logic                 mid_full,
  output logic                 mid_push,
  output pact_pkg::mid_item_t  mid_item
);

  logic                vld_r, vld_nxt;
  pact_pkg::mid_item_t item_r, item_nxt;
  logic                accept, keep;

  assign full     = vld_r & mid_full;
  assign mid_push = vld_r & ~mid_full;
  assign mid_item = item_r;

  always_comb begin
    accept = push & ~full;
    // NaN and the unused class code give no result
    keep   = (in_data.coord_class == pact_pkg::CLS_FINITE) ||
             (in_data.coord_class == pact_pkg::CLS_INFINITE);
    item_nxt = item_r;
    vld_nxt  = vld_r & mid_full;
    if (accept) begin
      vld_nxt            = keep;
      item_nxt.x         = in_data.pt_x;
      item_nxt.y         = in_data.pt_y;
      item_nxt.z         = in_data.pt_z;
      item_nxt.intensity = in_data.pt_intensity;
      item_nxt.ring      = in_data.pt_ring;
      item_nxt.infinite  = (in_data.coord_class == pact_pkg::CLS_INFINITE);
      item_nxt.xform     = in_data.from_secondary & xform_en &
                           (in_data.coord_class == pact_pkg::CLS_FINITE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== rtl/pact_queue.sv =====
module pact_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  pact_pkg::mid_item_t  wr_item,
  output logic                 q_full,
  input  logic                 rd_en,
  output pact_pkg::mid_item_t  rd_item,
  output logic                 q_empty
);

  pact_pkg::mid_item_t             mem [pact_pkg::MID_DEPTH];
  logic [pact_pkg::MID_PTR_W-1:0]  wptr_r, rptr_r;
  logic [pact_pkg::MID_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            wr, rd;

  assign q_full  = (cnt_r == pact_pkg::MID_CNT_W'(pact_pkg::MID_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_item = mem[rptr_r];
  assign wr      = wr_en & ~q_full;
  assign rd      = rd_en & ~q_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/pact_back.sv =====
`include "point_affine_transform_close_crop_top_macros.svh"

module pact_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pact_pkg::cfg_t       cfg,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  input  pact_pkg::mid_item_t  mid_item,
  input  logic                 pop,
  output logic                 empty,
  output pact_pkg::out_item_t  out_data
);

  localparam int CW   = pact_pkg::CW;
  localparam int PW   = pact_pkg::PW;
  localparam int AW   = pact_pkg::AW;
  localparam int RW   = pact_pkg::RW;
  localparam int FRAC = pact_pkg::FRAC;
  localparam int CMPW = pact_pkg::CMPW;
  localparam int SQW  = pact_pkg::SQW;

  localparam logic signed [RW-1:0] SAT_HI = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [AW-1:0] RND    = {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // pipeline: products, row sum and round, saturate, squares, crop and store
  logic                       s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  pact_pkg::mid_item_t        s1_item_r, s2_item_r, s3_item_r, s4_item_r;
  pact_pkg::mid_item_t        s3_item_nxt;
  logic signed [PW-1:0]       s1_prod_r [3][3];
  logic signed [PW-1:0]       prod_nxt  [3][3];
  logic signed [AW-1:0]       acc       [3];
  logic signed [RW-1:0]       s2_res_r  [3];
  logic signed [RW-1:0]       res_nxt   [3];
  logic signed [CW-1:0]       crd       [3];
  logic [2*CW-1:0]            s4_sqx_r, s4_sqy_r;
  logic [CW-1:0]              s4_ay_r;
  logic [CW-1:0]              ax, ay;
  logic [SQW-1:0]             sq_sum;
  logic                       crop, keep;

  pact_pkg::out_item_t              omem [pact_pkg::OUT_DEPTH];
  logic [pact_pkg::OUT_PTR_W-1:0]   owptr_r, orptr_r;
  logic [pact_pkg::OUT_CNT_W-1:0]   ocnt_r, ocnt_nxt;
  logic [2:0]                       inflight;
  logic                             wr, rd;
  pact_pkg::out_item_t              wr_item;

  assign inflight = 3'($countones({s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r}));
  assign mid_pop  = ~mid_empty &&
                    ((32'(ocnt_r) + 32'(inflight)) < pact_pkg::OUT_DEPTH);

  always_comb begin
    crd[0] = mid_item.x;
    crd[1] = mid_item.y;
    crd[2] = mid_item.z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = PW'($signed(cfg.rows[r][16*(3-c) +: 16])) * PW'(crd[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(s1_prod_r[r][0]) + AW'(s1_prod_r[r][1]) + AW'(s1_prod_r[r][2]) +
               (AW'($signed(cfg.rows[r][15:0])) <<< FRAC) + RND;
      res_nxt[r] = $signed(acc[r][AW-1:FRAC]);
    end
  end

  always_comb begin
    s3_item_nxt = s2_item_r;
    if (s2_item_r.xform) begin
      s3_item_nxt.x = sat(s2_res_r[0]);
      s3_item_nxt.y = sat(s2_res_r[1]);
      s3_item_nxt.z = sat(s2_res_r[2]);
    end
    ax = mag(s3_item_r.x);
    ay = mag(s3_item_r.y);
  end

  always_comb begin
    sq_sum = SQW'(s4_sqx_r) + SQW'(s4_sqy_r);
    crop   = (CMPW'(sq_sum) < CMPW'(cfg.radius_sq)) &&
             (CMPW'(s4_ay_r) < CMPW'(cfg.lateral));
    keep   = s4_item_r.infinite | ~crop;
    wr     = s4_vld_r & keep;
    rd     = pop & ~empty;
    wr_item.out_x         = s4_item_r.x;
    wr_item.out_y         = s4_item_r.y;
    wr_item.out_z         = s4_item_r.z;
    wr_item.out_intensity = s4_item_r.intensity;
    wr_item.out_ring      = s4_item_r.ring;
    wr_item.out_infinite  = s4_item_r.infinite;
    ocnt_nxt = ocnt_r;
    if (wr && !rd) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (rd && !wr) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  assign empty    = (ocnt_r == '0);
  assign out_data = omem[orptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      owptr_r  <= '0;
      orptr_r  <= '0;
      ocnt_r   <= '0;
    end else begin
      s1_vld_r <= mid_pop;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      if (wr) begin
        owptr_r <= owptr_r + 1'b1;
      end
      if (rd) begin
        orptr_r <= orptr_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= mid_item;
    s1_prod_r <= prod_nxt;
    s2_item_r <= s1_item_r;
    s2_res_r  <= res_nxt;
    s3_item_r <= s3_item_nxt;
    s4_item_r <= s3_item_r;
    s4_sqx_r  <= (2*CW)'(ax) * (2*CW)'(ax);
    s4_sqy_r  <= (2*CW)'(ay) * (2*CW)'(ay);
    s4_ay_r   <= ay;
    if (wr) begin
      omem[owptr_r] <= wr_item;
    end
  end

  `PACT_ASSERT_IMPL(a_credit, 1'b1, (32'(ocnt_r) + 32'(inflight)) <= pact_pkg::OUT_DEPTH, "credit overrun")
  `PACT_ASSERT_IMPL(a_room, wr, (32'(ocnt_r) < pact_pkg::OUT_DEPTH) || rd, "result queue overflow")
  `PACT_ASSERT_IMPL(a_inf_pass, s3_vld_r && s3_item_r.infinite, !s3_item_r.xform, "infinite transformed")
  `PACT_ASSERT_NEXT(a_pull, mid_pop, s1_vld_r, "pulled item lost")

endmodule

// ===== rtl/point_affine_transform_close_crop_top.sv =====
// Affine point transform with close-range crop.
// Input channel: drive in_data and raise push; a point transfers on a rising
// edge with push high and full low. NaN points are dropped at once.
// Result channel: while empty is low the oldest result is on out_data; it
// transfers on a rising edge with pop high. Finite points inside the close box
// are dropped, so a point gives zero or one result, always in arrival order.
// Configuration: cfg_ready is always high; a write transfers on cfg_valid.
// Write registers only while no point is in flight; the block does not check it.
// A kept point passes the front register, middle queue, pipeline and result queue.
// Throughput: one point per cycle while pop keeps up; the front register, the
// middle queue and the four-stage transform pipeline (nine parallel 16 x 20
// multipliers) each take a new point every cycle unless a full queue holds it.
// When pop is held low the 8-entry result queue fills, the pipeline stops
// pulling from the 4-entry middle queue, and full then rises.
// Reset (rst_n low, synchronous) empties all queues and loads the identity
// matrix, transform enabled, radius squared 7290000 and lateral limit 1250.
module point_affine_transform_close_crop_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  pact_pkg::in_item_t                 in_data,
  output logic                               empty,
  input  logic                               pop,
  output pact_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pact_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pact_pkg::CFG_W-1:0]         cfg_data
);

  logic [pact_pkg::CFG_W-1:0] row_x_r, row_y_r, row_z_r;
  logic                       xform_en_r;
  logic [pact_pkg::RAD_W-1:0] radius_r;
  logic [pact_pkg::LAT_W-1:0] lateral_r;
  pact_pkg::cfg_t             cfg;

  logic                       f_push, q_full, q_empty, q_pop;
  pact_pkg::mid_item_t        f_item, q_item;

  assign cfg_ready     = 1'b1;
  assign cfg.rows      = {row_z_r, row_y_r, row_x_r};
  assign cfg.radius_sq = radius_r;
  assign cfg.lateral   = lateral_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r    <= pact_pkg::ROW_X_RST;
      row_y_r    <= pact_pkg::ROW_Y_RST;
      row_z_r    <= pact_pkg::ROW_Z_RST;
      xform_en_r <= 1'b1;
      radius_r   <= pact_pkg::RADIUS_RST;
      lateral_r  <= pact_pkg::LAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (pact_pkg::cfg_reg_t'(cfg_index))
        pact_pkg::REG_ROW_X:     row_x_r    <= cfg_data;
        pact_pkg::REG_ROW_Y:     row_y_r    <= cfg_data;
        pact_pkg::REG_ROW_Z:     row_z_r    <= cfg_data;
        pact_pkg::REG_XFORM_EN:  xform_en_r <= cfg_data[0];
        pact_pkg::REG_RADIUS_SQ: radius_r   <= cfg_data[pact_pkg::RAD_W-1:0];
        pact_pkg::REG_LATERAL:   lateral_r  <= cfg_data[pact_pkg::LAT_W-1:0];
        default: ;
      endcase
    end
  end

  pact_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .xform_en (xform_en_r),
    .mid_full (q_full),
    .mid_push (f_push),
    .mid_item (f_item)
  );

  pact_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_item (f_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .q_empty (q_empty)
  );

  pact_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .mid_empty (q_empty),
    .mid_pop   (q_pop),
    .mid_item  (q_item),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule
